FILE: rtl/indexed_deque_list_assert.svh
// ---------------------------------------------------------------------------
// indexed_deque_list assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_LIST_ASSERT_SVH
`define INDEXED_DEQUE_LIST_ASSERT_SVH

// expression must hold at every clock edge out of reset
`define IDL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/idl_pkg.sv
// ---------------------------------------------------------------------------
// idl_pkg
// Constants, codes and controller/datapath interface types of the list.
// ---------------------------------------------------------------------------
package idl_pkg;

  // sizing
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW       = $clog2(CAPACITY);      // entry address
  localparam int unsigned CW       = $clog2(CAPACITY + 1);  // count
  localparam int unsigned DW       = 32;                    // word
  localparam int unsigned ACTW     = 4;
  localparam int unsigned PW       = 7;                     // position field
  localparam int unsigned STW      = 2;

  // request actions
  localparam logic [ACTW-1:0] A_PUSH_BACK  = 4'd0;
  localparam logic [ACTW-1:0] A_PUSH_FRONT = 4'd1;
  localparam logic [ACTW-1:0] A_POP_BACK   = 4'd2;
  localparam logic [ACTW-1:0] A_POP_FRONT  = 4'd3;
  localparam logic [ACTW-1:0] A_PEEK_BACK  = 4'd4;
  localparam logic [ACTW-1:0] A_PEEK_FRONT = 4'd5;
  localparam logic [ACTW-1:0] A_READ_AT    = 4'd6;
  localparam logic [ACTW-1:0] A_INSERT_AT  = 4'd7;
  localparam logic [ACTW-1:0] A_REMOVE_AT  = 4'd8;
  localparam logic [ACTW-1:0] A_CLEAR      = 4'd9;

  // result status
  localparam logic [STW-1:0] ST_OK    = 2'd0;
  localparam logic [STW-1:0] ST_RANGE = 2'd1;
  localparam logic [STW-1:0] ST_FULL  = 2'd2;

  localparam logic signed [DW-1:0] NEG_ONE = '1;

  // controller -> datapath commands
  typedef struct packed {
    logic           ld_req;   // latch the incoming request
    logic           rd_en;    // registered memory read
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           wr_val;   // 1: write request value, 0: write read data
    logic           res_set;  // result <= -1, status <= st
    logic [STW-1:0] st;
    logic           res_ld;   // result <= read data
    logic           cnt_inc;
    logic           cnt_dec;
    logic           cnt_clr;
    logic           out_ld;   // move result into the output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [ACTW-1:0] act;
    logic [PW-1:0]   pos;
    logic [CW-1:0]   count;
    logic            out_free;
  } sts_t;

endpackage

FILE: rtl/idl_datapath.sv
// ---------------------------------------------------------------------------
// idl_datapath
// Entry memory, occupancy counter, request latch, result and output register.
// ---------------------------------------------------------------------------
`include "indexed_deque_list_assert.svh"

module idl_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  idl_pkg::cmd_t           cmd,
  output idl_pkg::sts_t           sts,
  input  logic [idl_pkg::ACTW-1:0]      req_act,
  input  logic [idl_pkg::PW-1:0]        req_pos,
  input  logic signed [idl_pkg::DW-1:0] req_val,
  input  logic                    out_tready,
  output logic                    out_valid,
  output logic signed [idl_pkg::DW-1:0] out_value,
  output logic [idl_pkg::STW-1:0] out_status,
  output logic [idl_pkg::CW-1:0]  out_count,
  output logic                    out_empty
);
  import idl_pkg::*;

  logic signed [DW-1:0] mem [CAPACITY];
  logic signed [DW-1:0] rdata_r;

  logic [ACTW-1:0]      act_r;
  logic [PW-1:0]        pos_r;
  logic signed [DW-1:0] val_r;
  logic [CW-1:0]        count_r;
  logic signed [DW-1:0] res_r;
  logic [STW-1:0]       st_r;

  logic                 out_valid_r;
  logic signed [DW-1:0] out_value_r;
  logic [STW-1:0]       out_status_r;
  logic [CW-1:0]        out_count_r;
  logic                 out_empty_r;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_val ? val_r : rdata_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr];
    end
  end

  // request latch and result registers
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      act_r <= req_act;
      pos_r <= req_pos;
      val_r <= req_val;
    end
    if (cmd.res_set) begin
      res_r <= NEG_ONE;
      st_r  <= cmd.st;
    end else if (cmd.res_ld) begin
      res_r <= rdata_r;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_clr) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  // output register: holds one finished result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_value_r  <= res_r;
      out_status_r <= st_r;
      out_count_r  <= count_r;
      out_empty_r  <= (count_r == '0);
    end
  end

  assign sts.act      = act_r;
  assign sts.pos      = pos_r;
  assign sts.count    = count_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_empty  = out_empty_r;

  `IDL_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "occupancy above capacity")
  `IDL_ASSERT_NEXT(a_count_clr, cmd.cnt_clr, count_r == '0, "clear left entries")
  `IDL_ASSERT_NEXT(a_count_inc, cmd.cnt_inc && !cmd.cnt_clr,
                   count_r == $past(count_r) + CW'(1), "insert did not grow the list")

endmodule

FILE: rtl/idl_ctrl.sv
// ---------------------------------------------------------------------------
// idl_ctrl
// Request decoder, sequencer and shift cursor of the list.
// ---------------------------------------------------------------------------
module idl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  idl_pkg::sts_t sts,
  output idl_pkg::cmd_t cmd
);
  import idl_pkg::*;

  localparam int unsigned SW = 3;
  localparam logic [SW-1:0] S_IDLE    = 3'd0;
  localparam logic [SW-1:0] S_DEC     = 3'd1;
  localparam logic [SW-1:0] S_RDW     = 3'd2;  // read data pending
  localparam logic [SW-1:0] S_RMW     = 3'd3;  // removed word pending
  localparam logic [SW-1:0] S_RMV     = 3'd4;  // shift toward the front
  localparam logic [SW-1:0] S_INS_W   = 3'd5;  // shift toward the back
  localparam logic [SW-1:0] S_INS_PUT = 3'd6;
  localparam logic [SW-1:0] S_DONE    = 3'd7;

  localparam int unsigned KW = 3;
  localparam logic [KW-1:0] K_ERR  = 3'd0;
  localparam logic [KW-1:0] K_CLR  = 3'd1;
  localparam logic [KW-1:0] K_READ = 3'd2;
  localparam logic [KW-1:0] K_REM  = 3'd3;
  localparam logic [KW-1:0] K_INS  = 3'd4;

  localparam int unsigned XW = (PW > CW) ? PW : CW;

  logic [SW-1:0] state_r, state_nxt;
  logic [CW-1:0] cur_r, cur_nxt;

  logic [KW-1:0]  kind;
  logic [CW-1:0]  idx;
  logic [STW-1:0] err_st;
  logic           full, empty;
  logic [XW-1:0]  pos_x, cnt_x;
  logic [CW:0]    cur_p1, cur_p2, cnt_w;
  logic [CW-1:0]  cur_m1, cur_m2, cnt_m1;

  assign full   = sts.count >= CW'(CAPACITY);
  assign empty  = sts.count == '0;
  assign pos_x  = XW'(sts.pos);
  assign cnt_x  = XW'(sts.count);
  assign cnt_w  = {1'b0, sts.count};
  assign cnt_m1 = sts.count - CW'(1);
  assign cur_p1 = {1'b0, cur_r} + (CW+1)'(1);
  assign cur_p2 = {1'b0, cur_r} + (CW+1)'(2);
  assign cur_m1 = cur_r - CW'(1);
  assign cur_m2 = cur_r - CW'(2);

  // request decode: every action but clear and the failed ones becomes insert, remove or read at an index
  always_comb begin
    kind   = K_ERR;
    idx    = '0;
    err_st = ST_OK;
    unique case (sts.act)
      A_PUSH_BACK: begin
        if (full) err_st = ST_FULL;
        else begin kind = K_INS; idx = sts.count; end
      end
      A_PUSH_FRONT: begin
        if (full) err_st = ST_FULL;
        else kind = K_INS;
      end
      A_POP_BACK, A_PEEK_BACK: begin
        if (empty) err_st = ST_RANGE;
        else begin
          kind = (sts.act == A_POP_BACK) ? K_REM : K_READ;
          idx  = cnt_m1;
        end
      end
      A_POP_FRONT, A_PEEK_FRONT: begin
        if (empty) err_st = ST_RANGE;
        else kind = (sts.act == A_POP_FRONT) ? K_REM : K_READ;
      end
      A_READ_AT, A_REMOVE_AT: begin
        if (pos_x >= cnt_x) err_st = ST_RANGE;
        else begin
          kind = (sts.act == A_READ_AT) ? K_READ : K_REM;
          idx  = CW'(sts.pos);
        end
      end
      A_INSERT_AT: begin
        if (pos_x > cnt_x) err_st = ST_RANGE;
        else if (full) err_st = ST_FULL;
        else begin kind = K_INS; idx = CW'(sts.pos); end
      end
      A_CLEAR: kind = K_CLR;
      default: err_st = ST_RANGE;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.ld_req = in_tvalid;
        if (in_tvalid) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.res_set = 1'b1;
        cmd.st      = err_st;
        unique case (kind)
          K_CLR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_DONE;
          end
          K_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx[AW-1:0];
            state_nxt   = S_RDW;
          end
          K_REM: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx[AW-1:0];
            cur_nxt     = idx;
            state_nxt   = S_RMW;
          end
          K_INS: begin
            if (idx == sts.count) begin
              cur_nxt   = idx;
              state_nxt = S_INS_PUT;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = cnt_m1[AW-1:0];
              cur_nxt     = sts.count;
              state_nxt   = S_INS_W;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDW: begin
        cmd.res_ld = 1'b1;
        state_nxt  = S_DONE;
      end
      S_RMW: begin
        cmd.res_ld = 1'b1;
        if (cur_p1 < cnt_w) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cur_p1[AW-1:0];
          state_nxt   = S_RMV;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_RMV: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = cur_r[AW-1:0];
        cur_nxt     = cur_p1[CW-1:0];
        if (cur_p2 < cnt_w) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cur_p2[AW-1:0];
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_INS_W: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = cur_r[AW-1:0];
        cur_nxt     = cur_m1;
        if (cur_m1 == idx) begin
          state_nxt = S_INS_PUT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cur_m2[AW-1:0];
        end
      end
      S_INS_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_val  = 1'b1;
        cmd.wr_addr = cur_r[AW-1:0];
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
    end
  end

endmodule

FILE: rtl/indexed_deque_list.sv
// ---------------------------------------------------------------------------
// indexed_deque_list
// Bounded ordered list of signed 32-bit words with end and indexed access.
// ---------------------------------------------------------------------------
// One request at a time: the list takes a request, works it through an
// entry memory with one read and one write port, and leaves one result in
// the output register. After that it takes the next request even if that
// result is still not taken. Errors and clear go from decode to done.
// Reads and peeks pass read wait, push back the put state, pop back
// removed-word wait. Insert and remove move every entry behind the
// index by one place, one entry per cycle. The next request is taken
// in the cycle after the result is loaded. A result still held in the
// output register stalls the next result, not the next accept. Push
// front and pop front are insert and remove at index 0, so they cost
// the full shift.
module indexed_deque_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // action[3:0], position[10:4], value[42:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // result_value[31:0], status[33:32],
                                  // count[40:34], empty_res[41]
);
  import idl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic signed [DW-1:0] out_value;
  logic [STW-1:0]       out_status;
  logic [CW-1:0]        out_count;
  logic                 out_empty;

  // sequencer
  idl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and result path
  idl_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_act    (in_tdata[3:0]),
    .req_pos    (in_tdata[10:4]),
    .req_val    (in_tdata[42:11]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (out_value),
    .out_status (out_status),
    .out_count  (out_count),
    .out_empty  (out_empty)
  );

  assign out_tdata = {6'b0, out_empty, out_count, out_status, out_value};

endmodule
